// ===== sv/rtt_pkg.sv =====
// shared types, sizes and codes for the retransmit timeout table
package rtt_pkg;

	localparam int ENTRIES   = 16;
	localparam int SEQ_BITS  = 16;
	localparam int TIME_BITS = 32;
	localparam int CNT_BITS  = $clog2(ENTRIES + 1);

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_ACK    = 2'd1;
	localparam logic [1:0] OP_POLL   = 2'd2;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_REMOVED  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_TIMEOUT  = 3'd5;
	localparam logic [2:0] ST_NONE     = 3'd6;

	typedef struct packed {
		logic [1:0]           operation;
		logic [SEQ_BITS-1:0]  seq_number;
		logic [TIME_BITS-1:0] now;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [SEQ_BITS-1:0] resend_seq;
		logic [CNT_BITS-1:0] outstanding;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                 load;
		logic [1:0]           op;
		logic [SEQ_BITS-1:0]  seq;
		logic [TIME_BITS-1:0] now;
		logic [TIME_BITS-1:0] timeout;
		logic                 append_en;
		logic                 shift_en;
		logic                 restamp_en;
	} cmd_t;

	typedef struct packed {
		logic                 valid;
		logic [SEQ_BITS-1:0]  seq;
		logic [TIME_BITS-1:0] stamp;
	} entry_t;

	// priority chain running from the oldest cell toward the newest
	typedef struct packed {
		logic                hit;
		logic [SEQ_BITS-1:0] seq;
	} chain_t;

endpackage

// ===== sv/rtt_cell.sv =====
// one table slot: holds an entry, compares it and hands it to its neighbor
module rtt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  rtt_pkg::cmd_t   cmd,
	input  logic            prev_valid,
	input  rtt_pkg::chain_t chain_in,
	input  rtt_pkg::entry_t from_next,
	output rtt_pkg::entry_t entry,
	output rtt_pkg::chain_t chain_out,
	output logic            hit_here
);

	logic                          valid_q;
	logic [rtt_pkg::SEQ_BITS-1:0]  seq_q;
	logic [rtt_pkg::TIME_BITS-1:0] stamp_q;
	logic                          match_q;
	logic                          expired_q;
	logic [rtt_pkg::TIME_BITS-1:0] elapsed;
	logic                          flag;
	logic                          append;
	logic                          shift;
	logic                          restamp;

	assign elapsed = cmd.now - stamp_q;

	always_comb begin
		case (cmd.op)
			rtt_pkg::OP_RECORD: flag = match_q;
			rtt_pkg::OP_ACK:    flag = match_q;
			rtt_pkg::OP_POLL:   flag = expired_q;
			default:            flag = 1'b0;
		endcase
	end

	assign hit_here      = flag & ~chain_in.hit;
	assign chain_out.hit = chain_in.hit | flag;
	assign chain_out.seq = chain_in.hit ? chain_in.seq : seq_q;

	assign append  = cmd.append_en & ~valid_q & prev_valid;
	assign shift   = cmd.shift_en & chain_out.hit;
	assign restamp = cmd.restamp_en & hit_here;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			match_q   <= 1'b0;
			expired_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				match_q   <= valid_q && (seq_q == cmd.seq);
				expired_q <= valid_q && (elapsed > cmd.timeout);
			end
			if (shift) begin
				valid_q <= from_next.valid;
			end else if (append) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			seq_q   <= from_next.seq;
			stamp_q <= from_next.stamp;
		end else if (append) begin
			seq_q   <= cmd.seq;
			stamp_q <= cmd.now;
		end else if (restamp) begin
			stamp_q <= cmd.now;
		end
	end

	assign entry.valid = valid_q;
	assign entry.seq   = seq_q;
	assign entry.stamp = stamp_q;

endmodule

// ===== sv/retransmit_timeout_table.sv =====
// Each transaction runs in two steps: in the accept cycle every cell compares its entry with
// the sequence number and the elapsed time at once and registers the result; in the
// second step a priority chain through all ENTRIES cells picks the oldest hit and the
// cells append, shift down or restamp once the output can take the response. A new
// transaction is accepted in the cycle after that; the compare and the priority chain are
// split into two steps, and the input is stalled while a transaction is in the second.
// The result register holds a finished response while the output is stalled, and the next
// request is still taken meanwhile; its second step then waits until that response leaves.
module retransmit_timeout_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          timeout_we,
	input  logic [rtt_pkg::TIME_BITS-1:0] timeout_ticks,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  rtt_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output rtt_pkg::rsp_t                 rsp
);

	logic [rtt_pkg::TIME_BITS-1:0] timeout_q;
	logic                          busy_q;
	logic [1:0]                    op_s1;
	logic [rtt_pkg::SEQ_BITS-1:0]  seq_s1;
	logic [rtt_pkg::TIME_BITS-1:0] now_s1;
	logic [rtt_pkg::CNT_BITS-1:0]  count_q;
	logic                          rsp_valid_q;
	rtt_pkg::rsp_t                 rsp_q;

	logic                          accept;
	logic                          fire;
	logic                          full;
	rtt_pkg::cmd_t                 cmd;
	rtt_pkg::rsp_t                 rsp_next;
	logic [rtt_pkg::CNT_BITS-1:0]  count_next;

	rtt_pkg::entry_t               entries   [rtt_pkg::ENTRIES];
	rtt_pkg::chain_t               chain     [rtt_pkg::ENTRIES+1];
	logic [rtt_pkg::ENTRIES-1:0]   hit_vec;
	logic [rtt_pkg::ENTRIES-1:0]   valid_vec;

	assign accept    = req_valid & ~busy_q;
	assign req_stall = busy_q;
	assign fire      = busy_q & (~rsp_valid_q | ~rsp_stall);
	assign full      = (count_q == rtt_pkg::CNT_BITS'(rtt_pkg::ENTRIES));

	assign chain[0].hit = 1'b0;
	assign chain[0].seq = '0;

	always_comb begin
		cmd.load       = accept;
		cmd.op         = op_s1;
		cmd.seq        = busy_q ? seq_s1 : req.seq_number;
		cmd.now        = busy_q ? now_s1 : req.now;
		cmd.timeout    = timeout_q;
		cmd.append_en  = fire && (op_s1 == rtt_pkg::OP_RECORD) && !chain[rtt_pkg::ENTRIES].hit;
		cmd.shift_en   = fire && (op_s1 == rtt_pkg::OP_ACK);
		cmd.restamp_en = fire && (op_s1 == rtt_pkg::OP_POLL);
	end

	for (genvar k = 0; k < rtt_pkg::ENTRIES; k++) begin : g_cell
		logic            prev_valid;
		rtt_pkg::entry_t from_next;

		if (k == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = entries[k-1].valid;
		end

		if (k == rtt_pkg::ENTRIES - 1) begin : g_last
			assign from_next = '0;
		end else begin : g_mid
			assign from_next = entries[k+1];
		end

		rtt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prev_valid(prev_valid),
			.chain_in  (chain[k]),
			.from_next (from_next),
			.entry     (entries[k]),
			.chain_out (chain[k+1]),
			.hit_here  (hit_vec[k])
		);

		assign valid_vec[k] = entries[k].valid;
	end

	always_comb begin
		rsp_next.status      = rtt_pkg::ST_NONE;
		rsp_next.resend_seq  = '0;
		count_next           = count_q;
		case (op_s1)
			rtt_pkg::OP_RECORD: begin
				if (chain[rtt_pkg::ENTRIES].hit) begin
					rsp_next.status = rtt_pkg::ST_DUP;
				end else if (full) begin
					rsp_next.status = rtt_pkg::ST_FULL;
				end else begin
					rsp_next.status = rtt_pkg::ST_ADDED;
					count_next      = count_q + 1'b1;
				end
			end
			rtt_pkg::OP_ACK: begin
				if (chain[rtt_pkg::ENTRIES].hit) begin
					rsp_next.status = rtt_pkg::ST_REMOVED;
					count_next      = count_q - 1'b1;
				end else begin
					rsp_next.status = rtt_pkg::ST_NOTFOUND;
				end
			end
			rtt_pkg::OP_POLL: begin
				if (chain[rtt_pkg::ENTRIES].hit) begin
					rsp_next.status     = rtt_pkg::ST_TIMEOUT;
					rsp_next.resend_seq = chain[rtt_pkg::ENTRIES].seq;
				end
			end
			default: begin
				rsp_next.status = rtt_pkg::ST_NONE;
			end
		endcase
		rsp_next.outstanding = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= rtt_pkg::TIME_BITS'(1);
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (timeout_we) begin
				timeout_q <= timeout_ticks;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= req.operation;
			seq_s1 <= req.seq_number;
			now_s1 <= req.now;
		end
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rtt_pkg::CNT_BITS'(rtt_pkg::ENTRIES))
		else $error("entry count beyond table size");

	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("entry count disagrees with valid cells");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(hit_vec))
		else $error("more than one cell selected");

	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(busy_q))
		else $error("response without a transaction in progress");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for retransmit_timeout_table with a scoreboard class
module tb_top;
	import rtt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 90;
	localparam int PHASE_ITEMS = 115;

	class rtt_scoreboard;
		logic [TIME_BITS-1:0] timeout;
		logic [SEQ_BITS-1:0]  held_seq[ENTRIES];
		logic [TIME_BITS-1:0] held_stamp[ENTRIES];
		int                   held;
		rsp_t                 due_responses[$];
		int                   errors;

		function new();
			timeout = 1;
			held = 0;
			errors = 0;
		endfunction

		function void set_timeout(logic [TIME_BITS-1:0] v);
			timeout = v;
		endfunction

		function int slot_of(logic [SEQ_BITS-1:0] s);
			int pos;
			pos = -1;
			for (int k = 0; k < held; k++)
				if (pos < 0 && held_seq[k] == s)
					pos = k;
			return pos;
		endfunction

		function rsp_t table_step(req_t r);
			rsp_t p;
			int pos;
			logic hit;
			logic [TIME_BITS-1:0] elapsed;
			p = '0;
			p.status = ST_NONE;
			hit = 1'b0;
			case (r.operation)
				OP_RECORD: begin
					pos = slot_of(r.seq_number);
					if (pos >= 0) begin
						p.status = ST_DUP;
					end else if (held >= ENTRIES) begin
						p.status = ST_FULL;
					end else begin
						held_seq[held] = r.seq_number;
						held_stamp[held] = r.now;
						held++;
						p.status = ST_ADDED;
					end
				end
				OP_ACK: begin
					pos = slot_of(r.seq_number);
					if (pos < 0) begin
						p.status = ST_NOTFOUND;
					end else begin
						for (int k = pos; k + 1 < held; k++) begin
							held_seq[k] = held_seq[k + 1];
							held_stamp[k] = held_stamp[k + 1];
						end
						held--;
						p.status = ST_REMOVED;
					end
				end
				OP_POLL: begin
					for (int k = 0; k < held && !hit; k++) begin
						elapsed = r.now - held_stamp[k];
						if (elapsed > timeout) begin
							hit = 1'b1;
							held_stamp[k] = r.now;
							p.resend_seq = held_seq[k];
							p.status = ST_TIMEOUT;
						end
					end
				end
				default: ;
			endcase
			p.outstanding = held[CNT_BITS-1:0];
			return p;
		endfunction

		function void note_request(req_t r);
			due_responses.push_back(table_step(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (due_responses.size() == 0) begin
				$error("response with no transaction outstanding");
				errors++;
				return;
			end
			want = due_responses.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.resend_seq !== want.resend_seq) begin
				$error("resend_seq: expected %0h, got %0h", want.resend_seq, got.resend_seq);
				errors++;
			end
			if (got.outstanding !== want.outstanding) begin
				$error("outstanding: expected %0d, got %0d", want.outstanding,
					got.outstanding);
				errors++;
			end
		endfunction

		function int waiting();
			return due_responses.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 timeout_we = 1'b0;
	logic [TIME_BITS-1:0] timeout_ticks = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;

	rtt_scoreboard sb = new();
	logic          hold_off_pending = 1'b0;
	logic          gaps_on = 1'b1;
	int            burst_left = 0;

	retransmit_timeout_table uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.timeout_we   (timeout_we),
		.timeout_ticks(timeout_ticks),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (timeout_we)
				sb.set_timeout(timeout_ticks);
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int mode;
		int len;
		int n;
		@(posedge arst_n);
		n = 0;
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len = $urandom_range(4, 40);
				repeat (len) begin
					case (mode)
						0: rsp_stall <= 1'b0;
						1: rsp_stall <= ($urandom_range(0, 2) == 0);
						default: rsp_stall <= (n % 3 != 0);
					endcase
					n++;
					@(posedge clk);
				end
			end
		end
	end

	function automatic req_t make_req(logic [1:0] op, logic [SEQ_BITS-1:0] s,
		logic [TIME_BITS-1:0] t);
		req_t r;
		r.operation = op;
		r.seq_number = s;
		r.now = t;
		return r;
	endfunction

	task automatic offer_item(input req_t r);
		if (gaps_on && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (gaps_on)
			burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIME_BITS-1:0] v);
		timeout_we <= 1'b1;
		timeout_ticks <= v;
		@(posedge clk);
		timeout_we <= 1'b0;
	endtask

	task automatic run_directed();
		offer_item(make_req(OP_POLL, 16'hA5A5, 32'h0));
		offer_item(make_req(OP_UNUSED, 16'h5A5A, 32'hFFFF_FFFF));
		offer_item(make_req(OP_ACK, 16'h1234, 32'h0));
		offer_item(make_req(OP_RECORD, 16'h0000, 32'h0));
		offer_item(make_req(OP_RECORD, 16'hFFFF, 32'hFFFF_FFFF));
		offer_item(make_req(OP_RECORD, 16'h0000, 32'h5));
		// elapsed wraps past zero for the newer entry
		offer_item(make_req(OP_POLL, 16'h0000, 32'h1));
		offer_item(make_req(OP_POLL, 16'h0000, 32'h2));
		for (int k = 1; k <= 14; k++)
			offer_item(make_req(OP_RECORD, 16'h1111 * k, 32'h10 + k));
		offer_item(make_req(OP_RECORD, 16'hBEEF, 32'h40));
		// duplicate while full
		offer_item(make_req(OP_RECORD, 16'h7777, 32'h41));
		offer_item(make_req(OP_ACK, 16'h7777, 32'h42));
	endtask

	task automatic run_random(input int n_items, input logic wrap_start);
		logic [SEQ_BITS-1:0]  pool[20];
		logic [TIME_BITS-1:0] tnow;
		req_t                 r;
		int                   pick;
		foreach (pool[k])
			pool[k] = $urandom_range(0, 65535);
		tnow = wrap_start ? 32'hFFFF_FFF0 - $urandom_range(0, 200) : $urandom;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				tnow = tnow + $urandom;
			else
				tnow = tnow + $urandom_range(0, 6);
			r.now = tnow;
			r.seq_number = pool[$urandom_range(0, 19)];
			if (pick < 40) begin
				r.operation = OP_RECORD;
			end else if (pick < 65) begin
				r.operation = OP_ACK;
			end else if (pick < 95) begin
				r.operation = OP_POLL;
			end else begin
				r.operation = ($urandom_range(0, 1) == 0) ? OP_UNUSED : OP_ACK;
				r.seq_number = $urandom_range(0, 65535);
			end
			offer_item(r);
		end
	endtask

	initial begin
		logic [TIME_BITS-1:0] timeouts[5];
		timeouts[0] = 32'd0;
		timeouts[1] = 32'hFFFF_FFFF;
		timeouts[2] = 32'd1;
		timeouts[3] = $urandom_range(2, 40);
		timeouts[4] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		run_directed();
		for (int p = 0; p < 5; p++) begin
			drain();
			write_timeout(timeouts[p]);
			gaps_on = (p != 1);
			if (p == 0 || p == 3)
				hold_off_pending = 1'b1;
			run_random(PHASE_ITEMS, p == 3);
		end
		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== retransmit_timeout_table.f =====
sv/rtt_pkg.sv
sv/rtt_cell.sv
sv/retransmit_timeout_table.sv
tb/sv/tb_top.sv
